@@ rtl/core/cesc_pkg.sv @@
package cesc_pkg;

  localparam int LEN_W   = 16;
  localparam int ACC_W   = 21;
  localparam int MAX_RES = 4;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEXX   = 3'd3,
    MODE_HEX    = 3'd4,
    MODE_U4     = 3'd5,
    MODE_U8     = 3'd6
  } mode_t;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_TRAIL_BSL  = 4'd1;
  localparam logic [3:0] ERR_OCT_RANGE  = 4'd2;
  localparam logic [3:0] ERR_HEX_EMPTY  = 4'd3;
  localparam logic [3:0] ERR_HEX_RANGE  = 4'd4;
  localparam logic [3:0] ERR_U4_SHORT   = 4'd5;
  localparam logic [3:0] ERR_U8_SHORT   = 4'd6;
  localparam logic [3:0] ERR_U8_RANGE   = 4'd7;
  localparam logic [3:0] ERR_SURROGATE  = 4'd8;
  localparam logic [3:0] ERR_UNKNOWN    = 4'd9;

  localparam logic [ACC_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [ACC_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [ACC_W-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [ACC_W-1:0] LIM_1B   = 21'h00007F;
  localparam logic [ACC_W-1:0] LIM_2B   = 21'h0007FF;
  localparam logic [ACC_W-1:0] LIM_3B   = 21'h00FFFF;
  localparam logic [ACC_W-1:0] BYTE_MAX = 21'h0000FF;

  // Decoder state carried from one source byte to the next.
  typedef struct packed {
    mode_t              mode;
    logic [ACC_W-1:0]   acc;
    logic [3:0]         dcnt;
    logic               ovf;
    logic [LEN_W-1:0]   bcnt;
  } dec_state_t;

  // One result item: exactly one of data byte, error report or end report.
  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic [3:0] err;
    logic       is_end;
  } res_item_t;

  // All results caused by one source byte.
  typedef struct packed {
    res_item_t [MAX_RES-1:0] item;
    logic [2:0]              cnt;
    logic [LEN_W-1:0]        len;
  } burst_t;

endpackage

@@ rtl/core/cesc_decode.sv @@
module cesc_decode (
  input  cesc_pkg::dec_state_t st,
  input  logic [7:0]           in_byte,
  output cesc_pkg::dec_state_t nxt,
  output cesc_pkg::burst_t     bst
);
  import cesc_pkg::*;

  function automatic res_item_t mk_data(input logic [7:0] b);
    res_item_t r;
    r = '0;
    r.data = b;
    r.is_data = 1'b1;
    return r;
  endfunction

  function automatic res_item_t mk_err(input logic [3:0] code);
    res_item_t r;
    r = '0;
    r.err = code;
    return r;
  endfunction

  logic             hv;
  logic [3:0]       hd;
  logic [24:0]      nv_u;
  logic [19:0]      nv_h;
  logic [ACC_W-1:0] acc_o;
  logic [3:0]       dc_inc;
  logic [3:0]       need;
  logic [ACC_W-1:0] cp;
  res_item_t [MAX_RES-1:0] it;
  logic [2:0]       n;
  logic             do_plain;
  logic             has_end;
  logic [2:0]       ndata;
  logic [LEN_W:0]   sum;
  logic [LEN_W-1:0] len_sat;

  always_comb begin
    hv = 1'b1;
    hd = 4'd0;
    case (in_byte) inside
      ["0":"9"]: hd = 4'(in_byte - "0");
      ["a":"f"]: hd = 4'(in_byte - "a" + 8'd10);
      ["A":"F"]: hd = 4'(in_byte - "A" + 8'd10);
      default:   hv = 1'b0;
    endcase
  end

  assign nv_u   = {st.acc, 4'b0000} + {21'd0, hd};
  assign nv_h   = {st.acc[15:0], 4'b0000} + {16'd0, hd};
  assign acc_o  = {st.acc[17:0], 3'b000} + {18'd0, in_byte[2:0]};
  assign dc_inc = st.dcnt + 4'd1;
  assign need   = (st.mode == MODE_U4) ? 4'd4 : 4'd8;
  assign cp     = nv_u[ACC_W-1:0];

  always_comb begin
    nxt      = st;
    it       = '0;
    n        = 3'd0;
    do_plain = 1'b0;
    has_end  = 1'b0;

    unique case (st.mode)
      MODE_ESC: begin
        nxt.mode = MODE_NORMAL;
        case (in_byte) inside
          8'd0: begin
            it[0] = mk_err(ERR_TRAIL_BSL);
            n = 3'd1;
            do_plain = 1'b1;
          end
          "a": begin it[0] = mk_data(8'd7);  n = 3'd1; end
          "b": begin it[0] = mk_data(8'd8);  n = 3'd1; end
          "f": begin it[0] = mk_data(8'd12); n = 3'd1; end
          "n": begin it[0] = mk_data(8'd10); n = 3'd1; end
          "r": begin it[0] = mk_data(8'd13); n = 3'd1; end
          "t": begin it[0] = mk_data(8'd9);  n = 3'd1; end
          "v": begin it[0] = mk_data(8'd11); n = 3'd1; end
          "\\", "?", "'", "\"": begin
            it[0] = mk_data(in_byte);
            n = 3'd1;
          end
          ["0":"7"]: begin
            nxt.mode = MODE_OCT;
            nxt.acc  = {18'd0, in_byte[2:0]};
            nxt.dcnt = 4'd1;
          end
          "x", "X": begin
            nxt.mode = MODE_HEXX;
            nxt.acc  = '0;
            nxt.ovf  = 1'b0;
          end
          "u", "U": begin
            nxt.mode = (in_byte == "u") ? MODE_U4 : MODE_U8;
            nxt.acc  = '0;
            nxt.dcnt = 4'd0;
          end
          default: begin
            it[0] = mk_err(ERR_UNKNOWN);
            n = 3'd1;
          end
        endcase
      end
      MODE_OCT: begin
        if (in_byte >= "0" && in_byte <= "7") begin
          nxt.acc  = acc_o;
          nxt.dcnt = dc_inc;
          if (dc_inc >= 4'd3) begin
            nxt.mode = MODE_NORMAL;
            it[0] = (acc_o > BYTE_MAX) ? mk_err(ERR_OCT_RANGE) : mk_data(acc_o[7:0]);
            n = 3'd1;
          end
        end else begin
          nxt.mode = MODE_NORMAL;
          it[0] = mk_data(st.acc[7:0]);
          n = 3'd1;
          do_plain = 1'b1;
        end
      end
      MODE_HEXX: begin
        if (hv) begin
          nxt.mode = MODE_HEX;
          nxt.acc  = {17'd0, hd};
          nxt.ovf  = 1'b0;
        end else begin
          nxt.mode = MODE_NORMAL;
          it[0] = mk_err(ERR_HEX_EMPTY);
          n = 3'd1;
          do_plain = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hv) begin
          if (nv_h > 20'h000FF) nxt.ovf = 1'b1;
          nxt.acc = {1'b0, nv_h};
        end else begin
          nxt.mode = MODE_NORMAL;
          it[0] = (st.ovf || st.acc > BYTE_MAX) ? mk_err(ERR_HEX_RANGE)
                                                : mk_data(st.acc[7:0]);
          n = 3'd1;
          nxt.ovf = 1'b0;
          do_plain = 1'b1;
        end
      end
      MODE_U4, MODE_U8: begin
        if (hv) begin
          if (nv_u > {4'd0, CP_MAX}) begin
            nxt.mode = MODE_NORMAL;
            it[0] = mk_err(ERR_U8_RANGE);
            n = 3'd1;
          end else begin
            nxt.acc  = cp;
            nxt.dcnt = dc_inc;
            if (dc_inc >= need) begin
              nxt.mode = MODE_NORMAL;
              if (cp >= SURR_LO && cp <= SURR_HI) begin
                it[0] = mk_err(ERR_SURROGATE);
                n = 3'd1;
              end else if (cp <= LIM_1B) begin
                it[0] = mk_data(cp[7:0]);
                n = 3'd1;
              end else if (cp <= LIM_2B) begin
                it[0] = mk_data({3'b110, cp[10:6]});
                it[1] = mk_data({2'b10, cp[5:0]});
                n = 3'd2;
              end else if (cp <= LIM_3B) begin
                it[0] = mk_data({4'b1110, cp[15:12]});
                it[1] = mk_data({2'b10, cp[11:6]});
                it[2] = mk_data({2'b10, cp[5:0]});
                n = 3'd3;
              end else begin
                it[0] = mk_data({5'b11110, cp[20:18]});
                it[1] = mk_data({2'b10, cp[17:12]});
                it[2] = mk_data({2'b10, cp[11:6]});
                it[3] = mk_data({2'b10, cp[5:0]});
                n = 3'd4;
              end
            end
          end
        end else begin
          nxt.mode = MODE_NORMAL;
          it[0] = mk_err((st.mode == MODE_U4) ? ERR_U4_SHORT : ERR_U8_SHORT);
          n = 3'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        nxt.mode = MODE_NORMAL;
        do_plain = 1'b1;
      end
    endcase

    // Ordinary text handling of the current byte, after any escape result.
    if (do_plain) begin
      if (in_byte == 8'd0) begin
        it[n[1:0]] = '0;
        it[n[1:0]].is_end = 1'b1;
        n = n + 3'd1;
        has_end = 1'b1;
      end else if (in_byte == "\\") begin
        nxt.mode = MODE_ESC;
      end else begin
        it[n[1:0]] = mk_data(in_byte);
        n = n + 3'd1;
      end
    end

    ndata = 3'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      ndata = ndata + {2'b00, it[i].is_data};
    end
    sum     = {1'b0, st.bcnt} + {{(LEN_W-2){1'b0}}, ndata};
    len_sat = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    nxt.bcnt = has_end ? '0 : len_sat;

    bst.item = it;
    bst.cnt  = n;
    bst.len  = len_sat;
  end

endmodule

@@ rtl/core/c_escape_unescaper_core.sv @@
// C string escape decoder. Source characters enter on the in_valid/in_ready
// channel, one byte per request; a zero byte ends the string. Results leave
// on the out_valid/out_ready channel, one per cycle while out_ready is high: a data byte
// (byte_valid), an error report (error_code nonzero) or an end report
// (end_of_string, with out_length holding the saturated count of data bytes
// in the string). last_of_run marks the final result caused by a source byte;
// a byte may cause no result at all, as a backslash does.
// An accepted request waits in the input register, then the decode logic
// loads its results into a result buffer.
// A request that causes zero or one result is taken every cycle while the
// receiver keeps out_ready high; one that causes more results (at most four,
// from a UTF-8 encoded code point) holds the decoder while the buffer drains.
// When the receiver stalls, the pending results hold steady and one further
// request is still taken into the input register before in_ready falls.
// Reset clears the decode state, the length count and both buffers.
module c_escape_unescaper_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [3:0] error_code,
  output logic       end_of_string,
  output logic [cesc_pkg::LEN_W-1:0] out_length,
  output logic       last_of_run
);
  import cesc_pkg::*;

  logic       in_full;
  logic [7:0] in_data;
  dec_state_t st;
  dec_state_t st_next;
  burst_t     dec_bst;
  res_item_t [MAX_RES-1:0] bst_item;
  logic [2:0] bst_cnt;
  logic [1:0] bst_idx;
  logic [LEN_W-1:0] bst_len;
  logic       last;
  logic       out_fire;
  logic       burst_free;
  logic       load;
  res_item_t  cur;

  cesc_decode u_decode (
    .st      (st),
    .in_byte (in_data),
    .nxt     (st_next),
    .bst     (dec_bst)
  );

  assign out_valid  = (bst_cnt != 3'd0);
  assign last       = ({1'b0, bst_idx} == (bst_cnt - 3'd1));
  assign out_fire   = out_valid && out_ready;
  assign burst_free = !out_valid || (out_fire && last);
  assign load       = in_full && burst_free;
  assign in_ready   = !in_full || load;

  assign cur           = bst_item[bst_idx];
  assign out_byte      = cur.data;
  assign byte_valid    = cur.is_data;
  assign error_code    = cur.err;
  assign end_of_string = cur.is_end;
  assign out_length    = cur.is_end ? bst_len : '0;
  assign last_of_run   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode <= MODE_NORMAL;
      st.acc  <= '0;
      st.dcnt <= '0;
      st.ovf  <= 1'b0;
      st.bcnt <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst_cnt <= '0;
      bst_idx <= '0;
    end else if (load) begin
      bst_cnt <= dec_bst.cnt;
      bst_idx <= '0;
    end else if (out_fire) begin
      if (last) begin
        bst_cnt <= '0;
      end else begin
        bst_idx <= bst_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bst_item <= dec_bst.item;
      bst_len  <= dec_bst.len;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, bst_idx} < bst_cnt))
    else $error("result index beyond burst");

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    bst_cnt <= 3'(MAX_RES))
    else $error("burst count too large");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({byte_valid, end_of_string, error_code != ERR_NONE}))
    else $error("result item is not exactly one kind");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> last_of_run)
    else $error("end report is not the last result of its request");

  a_held_request: assert property (@(posedge clk) disable iff (rst)
    (in_full && !burst_free) |=> (in_full && $stable(in_data)))
    else $error("held request lost while results pending");
`endif

endmodule
